// ===== rtl/skf_pkg.sv =====
// shared types, constants and arithmetic helpers for skeleton forward kinematics
`timescale 1ns / 1ps
package skf_pkg;

  localparam int DEF_MAX_JOINTS   = 64;
  localparam int DEF_CORDIC_STEPS = 24;
  localparam int STORE_WORDS      = 12;  // nine rotation entries, three translation entries
  localparam int TRANS_BASE       = 9;

  typedef enum logic [1:0] {
    CMD_ROOT  = 2'd0,
    CMD_CHILD = 2'd1,
    CMD_CHAN  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  localparam logic [2:0] KIND_TX = 3'd0;
  localparam logic [2:0] KIND_TY = 3'd1;
  localparam logic [2:0] KIND_TZ = 3'd2;
  localparam logic [2:0] KIND_RX = 3'd3;
  localparam logic [2:0] KIND_RY = 3'd4;
  localparam logic [2:0] KIND_RZ = 3'd5;

  localparam logic signed [31:0] ONE_Q30    = 32'sd1073741824;
  localparam logic signed [65:0] HALF_Q30   = 66'sd536870912;
  localparam logic signed [31:0] DEG2RAD    = 32'sd18740330;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [33:0] FULL_TURN  = 34'sd23592960;  // 360 degrees, Q16.16
  localparam logic signed [33:0] HALF_TURN  = 34'sd11796480;
  localparam logic signed [33:0] QUARTER_TURN = 34'sd5898240;
  localparam logic [2:0]         MOD_STEPS_M1 = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_XLATE,
    ST_MOD,
    ST_FOLD,
    ST_ZMUL,
    ST_ZRND,
    ST_CORDIC,
    ST_CLAMP,
    ST_ROT,
    ST_CHK,
    ST_STORE,
    ST_EMIT
  } state_t;

  function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0:  r = 34'sd843314857;
      5'd1:  r = 34'sd497837829;
      5'd2:  r = 34'sd263043837;
      5'd3:  r = 34'sd133525159;
      5'd4:  r = 34'sd67021687;
      5'd5:  r = 34'sd33543516;
      5'd6:  r = 34'sd16775851;
      5'd7:  r = 34'sd8388437;
      5'd8:  r = 34'sd4194283;
      5'd9:  r = 34'sd2097149;
      5'd10: r = 34'sd1048576;
      5'd11: r = 34'sd524288;
      5'd12: r = 34'sd262144;
      5'd13: r = 34'sd131072;
      5'd14: r = 34'sd65536;
      5'd15: r = 34'sd32768;
      5'd16: r = 34'sd16384;
      5'd17: r = 34'sd8192;
      5'd18: r = 34'sd4096;
      5'd19: r = 34'sd2048;
      5'd20: r = 34'sd1024;
      5'd21: r = 34'sd512;
      5'd22: r = 34'sd256;
      5'd23: r = 34'sd128;
      5'd24: r = 34'sd64;
      5'd25: r = 34'sd32;
      5'd26: r = 34'sd16;
      5'd27: r = 34'sd8;
      5'd28: r = 34'sd4;
      5'd29: r = 34'sd2;
      5'd30: r = 34'sd1;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // round to nearest, ties up, Q2.30 product down to target format
  function automatic logic signed [65:0] rnd30(input logic signed [65:0] v);
    logic signed [65:0] r;
    r = (v + HALF_Q30) >>> 30;
    return r;
  endfunction

  function automatic logic signed [31:0] clamp30(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'(ONE_Q30)) r = ONE_Q30;
    else if (v < -34'(ONE_Q30)) r = -ONE_Q30;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== rtl/skf_if.sv =====
// handshake channel interfaces for joint/channel items and joint positions
`timescale 1ns / 1ps
interface skf_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [5:0]         parent_index;
  logic signed [31:0] offset_x;
  logic signed [31:0] offset_y;
  logic signed [31:0] offset_z;
  logic [2:0]         channel_count;
  logic [2:0]         channel_kind;
  logic signed [31:0] channel_value;

  modport source (output valid, command, parent_index, offset_x, offset_y, offset_z,
                  channel_count, channel_kind, channel_value, input ready);
  modport sink (input valid, command, parent_index, offset_x, offset_y, offset_z,
                channel_count, channel_kind, channel_value, output ready);
endinterface

interface skf_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         joint_index;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;

  modport source (output valid, joint_index, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, joint_index, pos_x, pos_y, pos_z, output ready);
endinterface

// ===== rtl/skeleton_forward_kinematics.sv =====
// skeleton forward kinematics: one shared multiplier and cordic under a sequencer
// per beat: a child joint reads its parent's 12 store words, forms 9 products on
// the shared multiplier and writes 12 store words; a translation channel forms 9
// products, a rotation channel runs angle reduction, the cordic and 12 products
// on the multiplier; one beat at a time, plus store/emit
// reset: identity transform, counters zero, rest mode off, joint store unset
`timescale 1ns / 1ps
module skeleton_forward_kinematics #(
  parameter int MAX_JOINTS   = skf_pkg::DEF_MAX_JOINTS,
  parameter int CORDIC_STEPS = skf_pkg::DEF_CORDIC_STEPS
) (
  input  logic     clk,
  input  logic     rst,
  skf_in_if.sink   in_ch,
  skf_out_if.source out_ch,
  input  logic     cfg_we,
  input  logic     cfg_wdata
);
  import skf_pkg::*;

  localparam int JCW       = $clog2(MAX_JOINTS + 1);
  localparam int MEM_DEPTH = MAX_JOINTS * STORE_WORDS;
  localparam int AW        = $clog2(MEM_DEPTH);

  state_t state, state_next;

  logic               rest_mode;
  logic signed [31:0] cur [STORE_WORDS];
  logic signed [31:0] vec [3];
  logic [2:0]         chleft;
  logic [JCW-1:0]     jc;
  logic               is_chan;
  logic               use_off;
  logic [AW-1:0]      base;
  logic [4:0]         stp;
  logic [1:0]         row, col, sub;
  logic               ph;
  logic [1:0]         rp, rq;
  logic signed [33:0] cx, cy, cz;
  logic               neg;
  logic signed [31:0] cos_v, sin_v, tmp;
  logic signed [65:0] acc;
  logic signed [63:0] prod;
  logic signed [31:0] mul_a, mul_b;

  logic [31:0]        mem [MEM_DEPTH];
  logic [31:0]        mem_rdata;
  logic [AW-1:0]      mem_raddr, mem_waddr, jbase;
  logic               mem_we;

  logic               out_valid;
  logic [5:0]         out_idx;
  logic signed [31:0] ox, oy, oz;

  logic               accept, emit_load, jc_full, fin;
  logic [2:0]         nsel;
  logic [3:0]         xi, ip, iq;
  logic signed [65:0] xsum, rsum;
  logic signed [33:0] mlim, fold_m;
  logic               fold_neg;

  assign accept  = in_ch.valid && in_ch.ready;
  assign jc_full = (jc >= JCW'(MAX_JOINTS));
  assign fin     = is_chan ? (chleft == 3'd1) : (chleft == 3'd0);
  assign nsel    = rest_mode ? 3'd0 : ((in_ch.channel_count == 3'd7) ? 3'd6 : in_ch.channel_count);
  assign jbase   = (AW'(jc) << 3) + (AW'(jc) << 2);
  assign xi      = 4'(row) * 4'd3 + 4'(col);
  assign ip      = 4'(row) * 4'd3 + 4'(rp);
  assign iq      = 4'(row) * 4'd3 + 4'(rq);
  assign xsum    = ((col == 2'd0) ? 66'(cur[TRANS_BASE + 32'(row)]) : acc) + rnd30(66'(prod));
  assign rsum    = (sub == 2'd1) ? (acc + 66'(prod)) : (acc - 66'(prod));
  assign mlim    = FULL_TURN << (MOD_STEPS_M1 - stp[2:0]);

  // fold reduced angle into [-90, 90], flipping sign of sin and cos
  always_comb begin
    fold_m   = cz;
    fold_neg = 1'b0;
    if (fold_m > HALF_TURN) fold_m = fold_m - FULL_TURN;
    if (fold_m > QUARTER_TURN) begin
      fold_m   = fold_m - HALF_TURN;
      fold_neg = 1'b1;
    end else if (fold_m < -QUARTER_TURN) begin
      fold_m   = fold_m + HALF_TURN;
      fold_neg = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_t'(in_ch.command))
            CMD_ROOT:  state_next = (nsel == 3'd0) ? ST_STORE : ST_IDLE;
            CMD_CHILD: state_next = ST_LOAD;
            CMD_CHAN: begin
              if (chleft == 3'd0) state_next = ST_IDLE;
              else if (in_ch.channel_kind <= KIND_TZ) state_next = ST_XLATE;
              else if (in_ch.channel_kind <= KIND_RZ) state_next = ST_MOD;
              else state_next = ST_CHK;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_LOAD:   if (stp == 5'd12) state_next = ST_XLATE;
      ST_XLATE:  if (ph && col == 2'd2 && row == 2'd2) state_next = ST_CHK;
      ST_MOD:    if (stp[2:0] == MOD_STEPS_M1) state_next = ST_FOLD;
      ST_FOLD:   state_next = ST_ZMUL;
      ST_ZMUL:   state_next = ST_ZRND;
      ST_ZRND:   state_next = ST_CORDIC;
      ST_CORDIC: if (stp == 5'(CORDIC_STEPS - 1)) state_next = ST_CLAMP;
      ST_CLAMP:  state_next = ST_ROT;
      ST_ROT:    if (ph && sub == 2'd3 && row == 2'd2) state_next = ST_CHK;
      ST_CHK:    state_next = (fin && !jc_full) ? ST_STORE : ST_IDLE;
      ST_STORE:  if (stp == 5'd11) state_next = ST_EMIT;
      ST_EMIT:   if (!out_valid || out_ch.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs and shared multiplier operands
  always_comb begin
    in_ch.ready = (state == ST_IDLE);
    emit_load   = (state == ST_EMIT) && (!out_valid || out_ch.ready);
    mem_we      = (state == ST_STORE);
    mem_waddr   = jbase + AW'(stp);
    mem_raddr   = base + AW'(stp);
    mul_a       = cur[xi];
    mul_b       = vec[col];
    case (state)
      ST_ZMUL: begin
        mul_a = cz[31:0];
        mul_b = DEG2RAD;
      end
      ST_ROT: begin
        mul_a = sub[0] ? sin_v : cos_v;
        case (sub)
          2'd0:    mul_b = cur[ip];
          2'd1:    mul_b = cur[iq];
          2'd2:    mul_b = cur[iq];
          default: mul_b = cur[ip];
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= cur[stp[3:0]];
    mem_rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) rest_mode <= 1'b0;
    else if (cfg_we) rest_mode <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // sequencer counters clear on every state change
  always_ff @(posedge clk) begin
    if (rst || state_next != state) begin
      stp <= '0;
      row <= '0;
      col <= '0;
      sub <= '0;
      ph  <= 1'b0;
    end else begin
      stp <= stp + 5'd1;
      ph  <= ~ph;
      if (ph) begin
        if (state == ST_XLATE) begin
          col <= (col == 2'd2) ? 2'd0 : col + 2'd1;
          if (col == 2'd2) row <= row + 2'd1;
        end else begin
          sub <= sub + 2'd1;
          if (sub == 2'd3) row <= row + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STORE_WORDS; i++) cur[i] <= '0;
      cur[0] <= ONE_Q30;
      cur[4] <= ONE_Q30;
      cur[8] <= ONE_Q30;
      chleft  <= '0;
      jc      <= '0;
      is_chan <= 1'b0;
      use_off <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (in_ch.command == CMD_ROOT || in_ch.command == CMD_CHILD) begin
              chleft  <= nsel;
              is_chan <= 1'b0;
              use_off <= (in_ch.command == CMD_ROOT) && rest_mode;
              vec[0]  <= in_ch.offset_x;
              vec[1]  <= in_ch.offset_y;
              vec[2]  <= in_ch.offset_z;
              if (in_ch.parent_index >= 6'(MAX_JOINTS - 1) && MAX_JOINTS <= 64)
                base <= (AW'(MAX_JOINTS - 1) << 3) + (AW'(MAX_JOINTS - 1) << 2);
              else
                base <= (AW'(in_ch.parent_index) << 3) + (AW'(in_ch.parent_index) << 2);
              if (in_ch.command == CMD_ROOT) begin
                jc <= '0;
                for (int i = 0; i < STORE_WORDS; i++) cur[i] <= '0;
                cur[0] <= ONE_Q30;
                cur[4] <= ONE_Q30;
                cur[8] <= ONE_Q30;
              end
            end else if (in_ch.command == CMD_CHAN && chleft != 3'd0) begin
              is_chan <= 1'b1;
              for (int i = 0; i < 3; i++)
                vec[i] <= (in_ch.channel_kind == 3'(i)) ? in_ch.channel_value : 32'sd0;
              cz <= 34'(in_ch.channel_value) + (FULL_TURN << 7);
              case (in_ch.channel_kind)
                KIND_RX: begin rp <= 2'd1; rq <= 2'd2; end
                KIND_RY: begin rp <= 2'd2; rq <= 2'd0; end
                default: begin rp <= 2'd0; rq <= 2'd1; end
              endcase
            end
          end
        end
        ST_LOAD: begin
          if (stp != 5'd0) cur[4'(stp - 5'd1)] <= mem_rdata;
        end
        ST_XLATE: begin
          if (ph) begin
            acc <= xsum;
            if (col == 2'd2) cur[TRANS_BASE + 32'(row)] <= sat32(xsum);
          end
        end
        ST_MOD: begin
          if (cz >= mlim) cz <= cz - mlim;
        end
        ST_FOLD: begin
          cz  <= fold_m;
          neg <= fold_neg;
        end
        ST_ZRND: begin
          cz <= 34'((prod + 64'sd32768) >>> 16);
          cx <= CORDIC_GAIN;
          cy <= '0;
        end
        ST_CORDIC: begin
          if (cz >= 0) begin
            cx <= cx - (cy >>> stp);
            cy <= cy + (cx >>> stp);
            cz <= cz - atan_entry(stp);
          end else begin
            cx <= cx + (cy >>> stp);
            cy <= cy - (cx >>> stp);
            cz <= cz + atan_entry(stp);
          end
        end
        ST_CLAMP: begin
          cos_v <= neg ? -clamp30(cx) : clamp30(cx);
          sin_v <= neg ? -clamp30(cy) : clamp30(cy);
        end
        ST_ROT: begin
          if (ph) begin
            case (sub)
              2'd0, 2'd2: acc <= 66'(prod) + HALF_Q30;
              2'd1:       tmp <= sat32(rsum >>> 30);
              default: begin
                cur[iq] <= sat32(rsum >>> 30);
                cur[ip] <= tmp;
              end
            endcase
          end
        end
        ST_CHK: begin
          if (is_chan) chleft <= chleft - 3'd1;
        end
        ST_EMIT: begin
          if (emit_load) jc <= jc + JCW'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (emit_load) out_valid <= 1'b1;
    else if (out_ch.ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_idx <= 6'(jc);
      ox      <= use_off ? vec[0] : cur[TRANS_BASE];
      oy      <= use_off ? vec[1] : cur[TRANS_BASE + 1];
      oz      <= use_off ? vec[2] : cur[TRANS_BASE + 2];
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.joint_index = out_idx;
  assign out_ch.pos_x       = ox;
  assign out_ch.pos_y       = oy;
  assign out_ch.pos_z       = oz;

  a_jc_bound: assert property (@(posedge clk) disable iff (rst) jc <= JCW'(MAX_JOINTS))
    else $error("joint counter past capacity");
  a_chleft_bound: assert property (@(posedge clk) disable iff (rst) chleft <= 3'd6)
    else $error("channel count out of range");
  a_store_cap: assert property (@(posedge clk) disable iff (rst) state == ST_STORE |-> !jc_full)
    else $error("store write beyond capacity");
  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_EMIT)
    else $error("result beat raised outside emit");
  a_trig_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_ROT |-> (cos_v <= ONE_Q30 && cos_v >= -ONE_Q30 &&
                         sin_v <= ONE_Q30 && sin_v >= -ONE_Q30))
    else $error("sin or cos out of unit range");

endmodule

// ===== tb/skf_checker.sv =====
// checker: predicts joint positions from accepted beats and compares output beats
`timescale 1ns / 1ps
module skf_checker (
  input  logic        clk,
  input  logic        rst,
  skf_in_if.sink      in_mon,
  skf_out_if.sink     out_mon,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  output int          errors,
  output int          pending
);
  import skf_pkg::*;

  localparam int NJ = DEF_MAX_JOINTS;

  typedef struct packed {
    logic [5:0]         idx;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } joint_pos_t;

  joint_pos_t         pos_q[$];
  logic               rest_sel;
  logic signed [31:0] rot_mem[NJ][9];
  logic signed [31:0] trn_mem[NJ][3];
  logic signed [31:0] rot[9];
  logic signed [31:0] trn[3];
  int                 owed;
  int                 jcount;

  localparam longint ATAN[32] = '{843314857, 497837829, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0};

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_q30(longint p);
    return (p + 64'sd536870912) >>> 30;
  endfunction

  task automatic move_by(input longint vx, input longint vy, input longint vz);
    longint acc;
    for (int r = 0; r < 3; r++) begin
      acc = trn[r] + round_q30(rot[r*3] * vx) + round_q30(rot[r*3+1] * vy)
            + round_q30(rot[r*3+2] * vz);
      trn[r] = 32'(clip32(acc));
    end
  endtask

  task automatic sincos_deg(input logic signed [31:0] deg, output longint co,
                            output longint si);
    longint full, m, z, x, y, dx, dy;
    bit     flip;
    full = 64'sd360 <<< 16;
    m = longint'(deg) % full;
    flip = 0;
    if (m < 0) m += full;
    if (m > (64'sd180 <<< 16)) m -= full;
    if (m > (64'sd90 <<< 16)) begin
      m -= 64'sd180 <<< 16; flip = 1;
    end else if (m < -(64'sd90 <<< 16)) begin
      m += 64'sd180 <<< 16; flip = 1;
    end
    z = (m * 64'sd18740330 + 32768) >>> 16;
    x = 64'sd652032874;
    y = 0;
    for (int i = 0; i < DEF_CORDIC_STEPS && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN[i];
      end else begin
        x += dx; y -= dy; z += ATAN[i];
      end
    end
    if (x > 64'sd1073741824) x = 64'sd1073741824;
    if (x < -64'sd1073741824) x = -64'sd1073741824;
    if (y > 64'sd1073741824) y = 64'sd1073741824;
    if (y < -64'sd1073741824) y = -64'sd1073741824;
    co = flip ? -x : x;
    si = flip ? -y : y;
  endtask

  task automatic spin(input int p, input int q, input logic signed [31:0] deg);
    longint c, s, a, b;
    sincos_deg(deg, c, s);
    for (int r = 0; r < 3; r++) begin
      a = rot[r*3+p];
      b = rot[r*3+q];
      rot[r*3+p] = 32'(clip32(round_q30(c * a + s * b)));
      rot[r*3+q] = 32'(clip32(round_q30(c * b - s * a)));
    end
  endtask

  task automatic close_joint(input bit show_off, input logic signed [31:0] ox,
                             input logic signed [31:0] oy, input logic signed [31:0] oz);
    joint_pos_t e;
    if (jcount >= NJ) return;
    rot_mem[jcount] = rot;
    trn_mem[jcount] = trn;
    e.idx = 6'(jcount);
    e.x = show_off ? ox : trn[0];
    e.y = show_off ? oy : trn[1];
    e.z = show_off ? oz : trn[2];
    pos_q = {pos_q, e};
    jcount++;
  endtask

  task automatic predict_beat();
    int          n;
    int          p;
    logic [2:0]  kind;
    if (in_mon.command == CMD_ROOT || in_mon.command == CMD_CHILD) begin
      n = (in_mon.channel_count == 3'd7) ? 6 : int'(in_mon.channel_count);
      if (rest_sel) n = 0;
      if (in_mon.command == CMD_ROOT) begin
        jcount = 0;
        rot = '{ONE_Q30, 0, 0, 0, ONE_Q30, 0, 0, 0, ONE_Q30};
        trn = '{0, 0, 0};
      end else begin
        p = int'(in_mon.parent_index);
        rot = rot_mem[p];
        trn = trn_mem[p];
        move_by(in_mon.offset_x, in_mon.offset_y, in_mon.offset_z);
      end
      owed = n;
      if (n == 0)
        close_joint(in_mon.command == CMD_ROOT && rest_sel, in_mon.offset_x,
                    in_mon.offset_y, in_mon.offset_z);
    end else if (in_mon.command == CMD_CHAN && owed != 0) begin
      kind = in_mon.channel_kind;
      case (kind)
        KIND_TX: move_by(in_mon.channel_value, 0, 0);
        KIND_TY: move_by(0, in_mon.channel_value, 0);
        KIND_TZ: move_by(0, 0, in_mon.channel_value);
        KIND_RX: spin(1, 2, in_mon.channel_value);
        KIND_RY: spin(2, 0, in_mon.channel_value);
        KIND_RZ: spin(0, 1, in_mon.channel_value);
        default: ;
      endcase
      owed--;
      if (owed == 0) close_joint(0, 0, 0, 0);
    end
  endtask

  assign pending = pos_q.size();

  always @(posedge clk) begin
    joint_pos_t e;
    if (rst) begin
      rest_sel <= 0;
      owed = 0;
      jcount = 0;
      rot = '{ONE_Q30, 0, 0, 0, ONE_Q30, 0, 0, 0, ONE_Q30};
      trn = '{0, 0, 0};
      errors <= 0;
    end else begin
      if (cfg_we) rest_sel <= cfg_wdata;
      if (in_mon.valid && in_mon.ready) predict_beat();
      if (out_mon.valid && out_mon.ready) begin
        if (pos_q.size() == 0) begin
          $display("%0t: unexpected beat joint %0d (%0d,%0d,%0d)", $time,
                   out_mon.joint_index, out_mon.pos_x, out_mon.pos_y, out_mon.pos_z);
          errors <= errors + 1;
        end else begin
          e = pos_q.pop_front();
          if (e.idx !== out_mon.joint_index || e.x !== out_mon.pos_x ||
              e.y !== out_mon.pos_y || e.z !== out_mon.pos_z) begin
            $display("%0t: expected joint %0d (%0d,%0d,%0d) got joint %0d (%0d,%0d,%0d)",
                     $time, e.idx, e.x, e.y, e.z, out_mon.joint_index,
                     out_mon.pos_x, out_mon.pos_y, out_mon.pos_z);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/testbench.sv =====
// top: clock, reset, stimulus for joints and channels, and the verdict
`timescale 1ns / 1ps
module testbench;
  import skf_pkg::*;

  localparam int WATCHDOG = 20000;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic cfg_wdata = 0;
  logic stall_rx = 0;
  int   errors;
  int   pending;
  int   idle_cycles = 0;
  int   written = 0;   // joints written since the last root, bounds parent choice
  int   n_items = 0;

  skf_in_if  in_ch();
  skf_out_if out_ch();

  skeleton_forward_kinematics u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  skf_checker u_chk (
    .clk(clk), .rst(rst), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .errors(errors), .pending(pending)
  );

  always #1 clk = ~clk;

  // receiver stall pattern: runs of stall and no-stall of random length
  int stall_run = 0;
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_rx <= ($urandom_range(0, 2) == 0);
      stall_run = $urandom_range(1, 40);
    end else stall_run--;
  end
  assign out_ch.ready = !stall_rx;

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("** skeleton_forward_kinematics: FAILED **");
      $finish;
    end
  end

  int burst_left = 0;

  task automatic send(input cmd_t cmd, input logic [5:0] par, input logic signed [31:0] ox,
                      input logic signed [31:0] oy, input logic signed [31:0] oz,
                      input logic [2:0] cnt, input logic [2:0] kind,
                      input logic signed [31:0] val);
    if (burst_left == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(0, 30)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid <= 1;
    in_ch.command <= cmd;
    in_ch.parent_index <= par;
    in_ch.offset_x <= ox;
    in_ch.offset_y <= oy;
    in_ch.offset_z <= oz;
    in_ch.channel_count <= cnt;
    in_ch.channel_kind <= kind;
    in_ch.channel_value <= val;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    n_items++;
  endtask

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      default: return 32'($signed($urandom_range(0, 400 << 16)) - (200 << 16));
    endcase
  endfunction

  // one joint with random content; parent is always an already stored joint
  task automatic send_joint(input bit root, input int nch);
    logic [5:0] par;
    if (written == 0) root = 1;
    par = root ? 6'($urandom) : 6'($urandom_range(0, written - 1));
    send(root ? CMD_ROOT : CMD_CHILD, par, rnd_word(), rnd_word(), rnd_word(),
         3'(nch), 3'($urandom), rnd_word());
    if (root) written = 0;
    if (nch == 0 || cfg_wdata) begin
      if (written < 64) written++;
    end else begin
      for (int i = 0; i < (nch == 7 ? 6 : nch); i++)
        send(CMD_CHAN, 6'($urandom), rnd_word(), rnd_word(), rnd_word(), 3'($urandom),
             3'($urandom_range(0, 7)), rnd_word());
      if (written < 64) written++;
    end
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  initial begin
    in_ch.valid = 0;
    in_ch.command = CMD_NONE;
    in_ch.parent_index = 0;
    in_ch.offset_x = 0;
    in_ch.offset_y = 0;
    in_ch.offset_z = 0;
    in_ch.channel_count = 0;
    in_ch.channel_kind = 0;
    in_ch.channel_value = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // directed: extremes, every channel kind, special cases
    send(CMD_ROOT, 0, 32'h7fffffff, 32'h80000000, 0, 3'd6, 0, 0);
    send(CMD_CHAN, 0, 0, 0, 0, 0, KIND_TX, 32'h7fffffff);
    send(CMD_CHAN, 0, 0, 0, 0, 0, KIND_TY, 32'h80000000);
    send(CMD_CHAN, 0, 0, 0, 0, 0, KIND_TZ, 32'sd65536);
    send(CMD_CHAN, 0, 0, 0, 0, 0, KIND_RX, 32'sd90 <<< 16);
    send(CMD_CHAN, 0, 0, 0, 0, 0, KIND_RY, -(32'sd270 <<< 16));
    send(CMD_CHAN, 0, 0, 0, 0, 0, KIND_RZ, 32'h80000000);
    send(CMD_CHAN, 0, 0, 0, 0, 0, KIND_RZ, 0);              // stray channel
    send(CMD_NONE, 6'h3f, 0, 0, 0, 3'd7, 3'd7, 32'hffffffff); // unused command
    send(CMD_CHILD, 0, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 3'd7, 0, 0);
    send(CMD_CHAN, 0, 0, 0, 0, 0, 3'd6, 32'h12345678);     // unknown kinds
    send(CMD_CHAN, 0, 0, 0, 0, 0, 3'd7, 32'h7fffffff);
    send(CMD_CHAN, 0, 0, 0, 0, 0, KIND_RX, 32'sd180 <<< 16);
    send(CMD_CHILD, 0, 32'sd65536, 0, 0, 3'd2, 0, 0);       // abandons unfinished joint
    send(CMD_CHAN, 0, 0, 0, 0, 0, KIND_RY, 32'sd45 <<< 16);
    send(CMD_CHAN, 0, 0, 0, 0, 0, KIND_TX, 32'sd65536);
    send(CMD_CHILD, 6'd1, 0, 32'sd65536, 0, 3'd0, 0, 0);
    written = 3;
    drain();

    // capacity: fill past 64 joints
    send_joint(1, 0);
    repeat (70) send_joint(0, $urandom_range(0, 1));
    drain();

    // rest pose, root reports its offset; mode flips while channels are owed
    cfg_we <= 1; cfg_wdata <= 1; @(negedge clk); cfg_we <= 0;
    send_joint(1, 3);
    repeat (10) send_joint(0, $urandom_range(0, 7));
    drain();
    cfg_we <= 1; cfg_wdata <= 0; @(negedge clk); cfg_we <= 0;
    send(CMD_ROOT, 0, 32'sd65536, 0, 0, 3'd2, 0, 0);
    in_ch.valid <= 0;
    cfg_we <= 1; cfg_wdata <= 1; @(negedge clk); cfg_we <= 0;
    send(CMD_CHAN, 0, 0, 0, 0, 0, KIND_RZ, 32'sd30 <<< 16);
    send(CMD_CHAN, 0, 0, 0, 0, 0, KIND_TX, 32'sd65536);
    drain();
    cfg_we <= 1; cfg_wdata <= 0; @(negedge clk); cfg_we <= 0;
    written = 0;

    // random: mostly well-formed skeletons, some noise and broken joints
    while (n_items < 1950) begin
      if (n_items > 1700 && !cfg_wdata && $urandom_range(0, 3) == 0) begin
        drain();
        cfg_we <= 1; cfg_wdata <= 1; @(negedge clk); cfg_we <= 0;
      end
      case ($urandom_range(0, 19))
        0: send(CMD_NONE, 6'($urandom), $urandom, $urandom, $urandom, 3'($urandom),
                3'($urandom), $urandom);
        1: send(CMD_CHAN, 6'($urandom), $urandom, $urandom, $urandom, 3'($urandom),
                3'($urandom), $urandom);
        2: if (written > 0) begin
             send(CMD_CHILD, 6'($urandom_range(0, written - 1)), rnd_word(), rnd_word(),
                  rnd_word(), 3'd4, 0, 0);
             send(CMD_CHAN, 0, 0, 0, 0, 0, 3'($urandom_range(0, 5)), rnd_word());
           end
        3: send_joint(1, $urandom_range(0, 7));
        default: send_joint(0, $urandom_range(0, 7));
      endcase
    end
    drain();

    if (errors == 0 && pending == 0) begin
      $display("** skeleton_forward_kinematics: PASSED **");
    end else begin
      $display("** skeleton_forward_kinematics: FAILED **");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/skf_pkg.sv
rtl/skf_if.sv
rtl/skeleton_forward_kinematics.sv
tb/skf_checker.sv
tb/testbench.sv
